>>> rtl/stlos_pkg.sv
// Shared constants and types for the wall-map line-of-sight block.
// Used by the front, queue, back and top modules; depends on nothing else.
`default_nettype none

package stlos_pkg;

  // Room size in tiles and fixed-point format of the segment coordinates
  localparam int ROOM_W    = 16;
  localparam int ROOM_H    = 16;
  localparam int FRAC_BITS = 8;

  // Field widths of the item ports
  localparam int COORD_W = 12;
  localparam int TILE_W  = 4;

  // Wall map geometry
  localparam int TILE_COUNT = ROOM_W * ROOM_H;
  localparam int ADDR_W     = $clog2(TILE_COUNT);
  localparam int XC_W       = $clog2(ROOM_W);
  localparam int ZC_W       = $clog2(ROOM_H);

  // Arithmetic widths: D_W holds a segment delta, E_W a point minus a tile
  // corner, ACC_W the cross products and their running sums.
  localparam int ROOM_MAX = (ROOM_W > ROOM_H) ? ROOM_W : ROOM_H;
  localparam int CORNER_W = $clog2(ROOM_MAX + 1) + FRAC_BITS;
  localparam int D_W      = COORD_W + 1;
  localparam int E_W      = ((CORNER_W > COORD_W) ? CORNER_W : COORD_W) + 1;
  localparam int ACC_W    = E_W + D_W + 2;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // One classified item as it travels from front to back
  typedef struct packed {
    op_e                op;
    logic               wr_en;
    logic [ADDR_W-1:0]  addr;
    logic               wall;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_z;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_z;
  } item_t;

  // Queue status seen by both of its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

>>> rtl/stlos_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; takes nothing from the package.
`default_nettype none

module stlos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/stlos_front.sv
// Front end: takes input transfers, classifies them and hands them to the queue.
// Depends on stlos_pkg for the item type and the room size.
`default_nettype none

module stlos_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            func_i,
  input  wire logic [stlos_pkg::TILE_W-1:0]    tile_x_i,
  input  wire logic [stlos_pkg::TILE_W-1:0]    tile_z_i,
  input  wire logic                            tile_is_wall_i,
  input  wire logic [stlos_pkg::COORD_W-1:0]   start_x_i,
  input  wire logic [stlos_pkg::COORD_W-1:0]   start_z_i,
  input  wire logic [stlos_pkg::COORD_W-1:0]   end_x_i,
  input  wire logic [stlos_pkg::COORD_W-1:0]   end_z_i,
  input  wire stlos_pkg::qstat_t               qstat_i,
  output logic                                 push_o,
  output stlos_pkg::item_t                     item_o
);

  logic             item_vld_q, item_vld_d;
  stlos_pkg::item_t item_q;
  stlos_pkg::item_t item_d;
  logic             accept;
  logic             in_room;

  // Stall while the held item cannot move on
  assign in_stall_o = item_vld_q && qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = item_vld_q && !qstat_i.full;

  // Classify: writes outside the room are turned into no-ops
  assign in_room = (int'(tile_x_i) < stlos_pkg::ROOM_W) &&
                   (int'(tile_z_i) < stlos_pkg::ROOM_H);

  always_comb begin
    item_d.op      = stlos_pkg::op_e'(func_i);
    item_d.wr_en   = in_room;
    item_d.addr    = stlos_pkg::ADDR_W'(int'(tile_x_i) * stlos_pkg::ROOM_H
                                        + int'(tile_z_i));
    item_d.wall    = tile_is_wall_i;
    item_d.start_x = start_x_i;
    item_d.start_z = start_z_i;
    item_d.end_x   = end_x_i;
    item_d.end_z   = end_z_i;
  end

  always_comb begin
    item_vld_d = item_vld_q;
    if (accept) begin
      item_vld_d = 1'b1;
    end else if (push_o) begin
      item_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
    end
  end

  // Hold the payload of the last accepted transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

>>> rtl/stlos_queue.sv
// Short FIFO of classified items between the front and the back.
// Depends on stlos_pkg for the item and status types and the depth.
`default_nettype none

module stlos_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire stlos_pkg::item_t  item_i,
  input  wire logic              pop_i,
  output stlos_pkg::item_t       head_o,
  output stlos_pkg::qstat_t      qstat_o
);

  localparam int PTR_W = (stlos_pkg::QUEUE_DEPTH > 1) ? $clog2(stlos_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(stlos_pkg::QUEUE_DEPTH + 1);

  stlos_pkg::item_t  mem_q [stlos_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(stlos_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign head_o        = mem_q[rd_ptr_q];
  assign qstat_o.full  = (cnt_q == CNT_W'(stlos_pkg::QUEUE_DEPTH));
  assign qstat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

>>> rtl/stlos_back.sv
// Back end: applies tile writes and scans the wall map for each query.
// Depends on stlos_pkg and on stlos_ram for the wall map storage.
`default_nettype none

module stlos_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire stlos_pkg::item_t  head_i,
  input  wire stlos_pkg::qstat_t qstat_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   blocked_o
);

  localparam int ADDR_W = stlos_pkg::ADDR_W;
  localparam int XC_W   = stlos_pkg::XC_W;
  localparam int ZC_W   = stlos_pkg::ZC_W;
  localparam int D_W    = stlos_pkg::D_W;
  localparam int E_W    = stlos_pkg::E_W;
  localparam int ACC_W  = stlos_pkg::ACC_W;
  localparam int FB     = stlos_pkg::FRAC_BITS;
  localparam int CW     = stlos_pkg::COORD_W;

  localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(stlos_pkg::TILE_COUNT - 1);
  localparam logic [ZC_W-1:0]     LAST_Z    = ZC_W'(stlos_pkg::ROOM_H - 1);
  localparam logic signed [E_W-1:0] ONE_E   = E_W'(1) <<< FB;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL1  = 3'd1;
  localparam logic [2:0] S_MUL2  = 3'd2;
  localparam logic [2:0] S_KSUB  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // num/den within [0, 1] without dividing; den is nonzero
  function automatic logic ratio_ok(input logic signed [ACC_W-1:0] num,
                                    input logic signed [ACC_W-1:0] den);
    if (den > 0) begin
      return (num >= 0) && (num <= den);
    end
    return (num <= 0) && (num >= den);
  endfunction

  // One edge test: n1/d1 is the scaled first ratio, n2 the full second numerator
  function automatic logic edge_hit(input logic signed [E_W-1:0]   n1,
                                    input logic signed [D_W-1:0]   d1,
                                    input logic signed [ACC_W-1:0] n2);
    logic signed [ACC_W-1:0] n1e;
    logic signed [ACC_W-1:0] d1e;
    logic signed [ACC_W-1:0] d2e;
    n1e = ACC_W'(n1);
    d1e = ACC_W'(d1);
    d2e = d1e <<< FB;
    if (d1 == '0) begin
      return (n1 == '0) && (n2 == '0);
    end
    return ratio_ok(n1e, d1e) && ratio_ok(n2, d2e);
  endfunction

  logic [2:0]                state_q, state_d;
  logic [CW-1:0]             ax_q, az_q;
  logic signed [D_W-1:0]     dx_q, dz_q;
  logic signed [ACC_W-1:0]   prod_q, k_q, p_q, q_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [XC_W-1:0]           tx_q;
  logic [ZC_W-1:0]           tz_q;
  logic [stlos_pkg::TILE_COUNT-1:0] vld_q;

  logic                      b_valid_q;
  logic                      vld_b_q;
  logic [XC_W-1:0]           tx_b_q;
  logic [ZC_W-1:0]           tz_b_q;
  logic signed [ACC_W-1:0]   f_b_q;
  logic                      hit_q;

  logic                      out_valid_q, out_valid_d;
  logic                      blocked_q;
  logic                      out_free;
  logic                      load_out;

  logic                      ram_we;
  logic                      ram_re;
  logic                      ram_rdata;

  logic signed [E_W-1:0]     mul_a;
  logic signed [D_W-1:0]     mul_b;
  logic signed [E_W+D_W-1:0] mul_p;
  logic signed [ACC_W-1:0]   dx1, dz1;
  logic signed [D_W-1:0]     dx_new, dz_new;

  logic signed [E_W-1:0]     ax_e, az_e, x0, x1, z0, z1;
  logic                      wall_b;
  logic                      tile_hit;

  assign pop_o    = (state_q == S_IDLE) && !qstat_i.empty;
  assign ram_we   = pop_o && (head_i.op == stlos_pkg::OP_WRITE) && head_i.wr_en;
  assign ram_re   = (state_q == S_SCAN);
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == S_DONE) && out_free;

  // Wall map storage; valid bits make unwritten tiles read as open floor
  stlos_ram #(
    .WIDTH (1),
    .DEPTH (stlos_pkg::TILE_COUNT)
  ) u_wall_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (head_i.addr),
    .wr_data_i (head_i.wall),
    .rd_en_i   (ram_re),
    .rd_addr_i (addr_q),
    .rd_data_o (ram_rdata)
  );

  // Sequence a query: two products for the constant term, then the scan
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop_o && (head_i.op == stlos_pkg::OP_QUERY)) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_KSUB;
      S_KSUB:  state_d = S_SCAN;
      S_SCAN: begin
        if (addr_q == LAST_ADDR) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      b_valid_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      b_valid_q   <= (state_q == S_SCAN);
      if (ram_we) begin
        vld_q[head_i.addr] <= 1'b1;
      end
      if (state_q == S_MUL1) begin
        hit_q <= 1'b0;
      end else if (b_valid_q && wall_b && tile_hit) begin
        hit_q <= 1'b1;
      end
    end
  end

  // Segment setup: deltas at pop, then K = az*dx - ax*dz in states MUL1, MUL2 and KSUB
  assign dx_new = $signed({1'b0, head_i.end_x}) - $signed({1'b0, head_i.start_x});
  assign dz_new = $signed({1'b0, head_i.end_z}) - $signed({1'b0, head_i.start_z});

  assign ax_e  = E_W'($signed({1'b0, ax_q}));
  assign az_e  = E_W'($signed({1'b0, az_q}));
  assign mul_a = (state_q == S_MUL1) ? az_e : ax_e;
  assign mul_b = (state_q == S_MUL1) ? dx_q : dz_q;
  assign mul_p = mul_a * mul_b;

  assign dx1 = ACC_W'(dx_q) <<< FB;
  assign dz1 = ACC_W'(dz_q) <<< FB;

  always_ff @(posedge clk_i) begin
    if (pop_o && (head_i.op == stlos_pkg::OP_QUERY)) begin
      ax_q <= head_i.start_x;
      az_q <= head_i.start_z;
      dx_q <= dx_new;
      dz_q <= dz_new;
    end
    case (state_q)
      S_MUL1: begin
        prod_q <= ACC_W'(mul_p);
        p_q    <= '0;
        q_q    <= '0;
        addr_q <= '0;
        tx_q   <= '0;
        tz_q   <= '0;
      end
      S_MUL2: begin
        prod_q <= ACC_W'(mul_p);
        k_q    <= prod_q;
      end
      S_KSUB: begin
        k_q <= k_q - prod_q;
      end
      S_SCAN: begin
        // Step the tile counters and the corner cross-product terms
        if (addr_q != LAST_ADDR) begin
          addr_q <= addr_q + ADDR_W'(1);
        end
        if (tz_q == LAST_Z) begin
          tz_q <= '0;
          q_q  <= '0;
          tx_q <= tx_q + XC_W'(1);
          p_q  <= p_q + dz1;
        end else begin
          tz_q <= tz_q + ZC_W'(1);
          q_q  <= q_q + dx1;
        end
      end
      default: begin
      end
    endcase
  end

  // Tile stage: aligned with the registered wall-map read
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN) begin
      vld_b_q <= vld_q[addr_q];
      tx_b_q  <= tx_q;
      tz_b_q  <= tz_q;
      f_b_q   <= k_q + p_q - q_q;
    end
  end

  assign wall_b = ram_rdata && vld_b_q;

  // Test every edge of the current tile
  assign x0 = E_W'({tx_b_q, {FB{1'b0}}});
  assign z0 = E_W'({tz_b_q, {FB{1'b0}}});
  assign x1 = x0 + ONE_E;
  assign z1 = z0 + ONE_E;

  assign tile_hit = edge_hit(az_e - z0, -dz_q, f_b_q) ||
                    edge_hit(x0 - ax_e, dx_q, f_b_q) ||
                    edge_hit(az_e - z1, -dz_q, f_b_q - dx1) ||
                    edge_hit(x1 - ax_e, dx_q, f_b_q + dz1);

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      blocked_q <= hit_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign blocked_o   = blocked_q;

  a_hit_from_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hit_q) |-> $past(b_valid_q && wall_b))
    else $error("hit flag set without a wall tile in the tile stage");

  a_drain_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> ($past(addr_q) == LAST_ADDR))
    else $error("scan ended before the last tile");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside the done state");

  a_tile_stage_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (state_q == S_SCAN || state_q == S_DRAIN))
    else $error("tile stage active outside a scan");

endmodule

`default_nettype wire

>>> rtl/segment_tile_map_line_of_sight.sv
// Wall-map line-of-sight block: top level joining front, queue and back.
// Depends on stlos_pkg, stlos_front, stlos_queue, stlos_back.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one item per
//   transfer. func_i = 0 writes tile_is_wall_i into tile (tile_x_i, tile_z_i)
//   and gives no result; tiles outside the room are ignored. func_i = 1
//   queries the segment (start_x_i, start_z_i)-(end_x_i, end_z_i), fixed
//   point with FRAC_BITS fraction bits, and gives one result on the output
//   channel (out_valid_o / out_stall_i): blocked_o = 1 when the segment meets
//   an edge of some wall tile.
//   A write is applied in the back end as it is popped from the queue. A
//   query steps the back end through MUL1, MUL2, KSUB, SCAN, DRAIN and
//   DONE; in SCAN it reads one tile a cycle from the single read port of
//   the wall map and tests each of its edges, and it pops no new item until
//   the result is loaded. An item passes the input register and the queue
//   before the back end; out_valid_o rises once DONE loads the result.
//   A two-entry queue and an input register let items be accepted while a
//   query is being scanned. If the receiver stalls, the result holds in the
//   output register; the back end waits and the queue fills, then in_stall_o
//   rises.
//   Reset clears all control state; the wall map reads as empty right away
//   through per-tile valid bits, with no clearing pass.
`default_nettype none

module segment_tile_map_line_of_sight (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          func_i,
  input  wire logic [stlos_pkg::TILE_W-1:0]  tile_x_i,
  input  wire logic [stlos_pkg::TILE_W-1:0]  tile_z_i,
  input  wire logic                          tile_is_wall_i,
  input  wire logic [stlos_pkg::COORD_W-1:0] start_x_i,
  input  wire logic [stlos_pkg::COORD_W-1:0] start_z_i,
  input  wire logic [stlos_pkg::COORD_W-1:0] end_x_i,
  input  wire logic [stlos_pkg::COORD_W-1:0] end_z_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               blocked_o
);

  stlos_pkg::item_t  front_item;
  stlos_pkg::item_t  head_item;
  stlos_pkg::qstat_t qstat;
  logic              push;
  logic              pop;

  // Accept and classify
  stlos_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .tile_x_i       (tile_x_i),
    .tile_z_i       (tile_z_i),
    .tile_is_wall_i (tile_is_wall_i),
    .start_x_i      (start_x_i),
    .start_z_i      (start_z_i),
    .end_x_i        (end_x_i),
    .end_z_i        (end_z_i),
    .qstat_i        (qstat),
    .push_o         (push),
    .item_o         (front_item)
  );

  // Decouple front and back
  stlos_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .qstat_o (qstat)
  );

  // Apply writes and scan queries
  stlos_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_item),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .blocked_o   (blocked_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the wall-map line-of-sight block: builds wall maps,
// queries segments, and checks each blocked result against an exact integer predictor.
// Depends on stlos_pkg and segment_tile_map_line_of_sight.
`default_nettype none

module testbench;

  localparam int ROOM_W         = stlos_pkg::ROOM_W;
  localparam int ROOM_H         = stlos_pkg::ROOM_H;
  localparam int FRAC_BITS      = stlos_pkg::FRAC_BITS;
  localparam int COORD_W        = stlos_pkg::COORD_W;
  localparam int TILE_W         = stlos_pkg::TILE_W;
  localparam int TILE_COUNT     = stlos_pkg::TILE_COUNT;
  localparam int IDLE_PCT       = 22;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 300;
  localparam int ONE            = 1 << FRAC_BITS;
  localparam int COORD_MAX      = (1 << COORD_W) - 1;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               func_i;
  logic [TILE_W-1:0]  tile_x_i;
  logic [TILE_W-1:0]  tile_z_i;
  logic               tile_is_wall_i;
  logic [COORD_W-1:0] start_x_i;
  logic [COORD_W-1:0] start_z_i;
  logic [COORD_W-1:0] end_x_i;
  logic [COORD_W-1:0] end_z_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               blocked_o;

  // Predictor state: wall flags and the blocked results still owed by the block
  bit   wall_model [TILE_COUNT];
  bit   blocked_pending_q [$];
  int   set_walls [$];
  logic idle_on;

  // Handshake state sampled at the falling edge, used at the next rising edge
  bit in_take_s;
  bit out_take_s;
  bit blocked_s;

  int errors        = 0;
  int items_sent    = 0;
  int queries_seen  = 0;
  int blocked_seen  = 0;
  int quiet_cycles  = 0;

  segment_tile_map_line_of_sight DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .tile_x_i       (tile_x_i),
    .tile_z_i       (tile_z_i),
    .tile_is_wall_i (tile_is_wall_i),
    .start_x_i      (start_x_i),
    .start_z_i      (start_z_i),
    .end_x_i        (end_x_i),
    .end_z_i        (end_z_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .blocked_o      (blocked_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Line-of-sight predictor, exact in 64-bit integers
  // ---------------------------------------------------------------------------

  // True when num/den lies in [0, 1]; den is nonzero
  function automatic bit ratio_in_unit(input longint num, input longint den);
    if (den > 0) return (num >= 0) && (num <= den);
    return (num <= 0) && (num >= den);
  endfunction

  // Segment a-b against tile edge c-d
  function automatic bit edge_hit(input longint ax, az, bx, bz, cx, cz, dx, dz);
    longint den, n1, n2;
    den = (bx - ax) * (dz - cz) - (bz - az) * (dx - cx);
    n1  = (az - cz) * (dx - cx) - (ax - cx) * (dz - cz);
    n2  = (az - cz) * (bx - ax) - (ax - cx) * (bz - az);
    // parallel edge: hit only when collinear
    if (den == 0) return (n1 == 0) && (n2 == 0);
    return ratio_in_unit(n1, den) && ratio_in_unit(n2, den);
  endfunction

  function automatic bit tile_hit(input longint ax, az, bx, bz, input int tx, tz);
    longint x0, z0, x1, z1;
    x0 = longint'(tx) * ONE;
    z0 = longint'(tz) * ONE;
    x1 = x0 + ONE;
    z1 = z0 + ONE;
    return edge_hit(ax, az, bx, bz, x0, z0, x1, z0) ||
           edge_hit(ax, az, bx, bz, x0, z0, x0, z1) ||
           edge_hit(ax, az, bx, bz, x0, z1, x1, z1) ||
           edge_hit(ax, az, bx, bz, x1, z0, x1, z1);
  endfunction

  function automatic bit sight_blocked(input logic [COORD_W-1:0] sx, sz, ex, ez);
    longint ax, az, bx, bz;
    ax = longint'(sx);
    az = longint'(sz);
    bx = longint'(ex);
    bz = longint'(ez);
    for (int i = 0; i < ROOM_W; i++) begin
      for (int j = 0; j < ROOM_H; j++) begin
        if (wall_model[i * ROOM_H + j] && tile_hit(ax, az, bx, bz, i, j)) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_MAX[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Drive one item, update the predictor, and hold it until the transfer
  task automatic send_item(input stlos_pkg::op_e op, input logic [TILE_W-1:0] tx, tz,
                           input logic wall, input logic [COORD_W-1:0] sx, sz, ex, ez);
    while (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= op;
    tile_x_i       <= tx;
    tile_z_i       <= tz;
    tile_is_wall_i <= wall;
    start_x_i      <= sx;
    start_z_i      <= sz;
    end_x_i        <= ex;
    end_z_i        <= ez;
    if (op == stlos_pkg::OP_WRITE) begin
      if (int'(tx) < ROOM_W && int'(tz) < ROOM_H) begin
        wall_model[int'(tx) * ROOM_H + int'(tz)] = wall;
      end
    end else begin
      blocked_pending_q.push_back(sight_blocked(sx, sz, ex, ez));
    end
    items_sent++;
    do @(posedge clk_i); while (!in_take_s);
  endtask

  // Write one tile flag, with noise in the ignored segment fields
  task automatic put_wall(input int idx, input logic wall);
    send_item(stlos_pkg::OP_WRITE, TILE_W'(idx / ROOM_H), TILE_W'(idx % ROOM_H), wall,
              COORD_W'($urandom_range(COORD_MAX)), COORD_W'($urandom_range(COORD_MAX)),
              COORD_W'($urandom_range(COORD_MAX)), COORD_W'($urandom_range(COORD_MAX)));
    if (wall) set_walls.push_back(idx);
  endtask

  // Query a segment, with noise in the ignored write fields
  task automatic query(input int sx, sz, ex, ez);
    send_item(stlos_pkg::OP_QUERY, TILE_W'($urandom_range(15)), TILE_W'($urandom_range(15)),
              1'($urandom_range(1)),
              COORD_W'(sx), COORD_W'(sz), COORD_W'(ex), COORD_W'(ez));
  endtask

  // Pick a segment from a mix of shapes that stress different edge cases
  task automatic pick_segment(output logic [COORD_W-1:0] sx, sz, ex, ez);
    int kind;
    int t;
    kind = $urandom_range(9);
    sx = COORD_W'($urandom_range(COORD_MAX));
    sz = COORD_W'($urandom_range(COORD_MAX));
    ex = COORD_W'($urandom_range(COORD_MAX));
    ez = COORD_W'($urandom_range(COORD_MAX));
    case (kind) inside
      [3:4]: begin
        ex = clamp_coord(int'(sx) + int'($urandom_range(1024)) - 512);
        ez = clamp_coord(int'(sz) + int'($urandom_range(1024)) - 512);
      end
      5: begin
        // aim at a known wall tile
        if (set_walls.size() > 0) begin
          t  = set_walls[$urandom_range(set_walls.size() - 1)];
          ex = COORD_W'((t / ROOM_H) * ONE + int'($urandom_range(ONE - 1)));
          ez = COORD_W'((t % ROOM_H) * ONE + int'($urandom_range(ONE - 1)));
        end
      end
      6: begin
        // run along a grid line
        if ($urandom_range(1)) begin
          sx = COORD_W'($urandom_range(ROOM_W - 1) * ONE);
          ex = sx;
        end else begin
          sz = COORD_W'($urandom_range(ROOM_H - 1) * ONE);
          ez = sz;
        end
      end
      7: begin
        // point segment, often on a grid line
        if ($urandom_range(1)) sx = COORD_W'($urandom_range(ROOM_W - 1) * ONE);
        ex = sx;
        ez = sz;
      end
      8: begin
        sx = $urandom_range(1) ? COORD_MAX[COORD_W-1:0] : '0;
        sz = $urandom_range(1) ? COORD_MAX[COORD_W-1:0] : '0;
        ex = $urandom_range(1) ? COORD_MAX[COORD_W-1:0] : '0;
        ez = $urandom_range(1) ? COORD_MAX[COORD_W-1:0] : '0;
      end
      9: begin
        // tile corner to tile corner
        sx = COORD_W'($urandom_range(ROOM_W - 1) * ONE);
        sz = COORD_W'($urandom_range(ROOM_H - 1) * ONE);
        ex = COORD_W'($urandom_range(ROOM_W - 1) * ONE);
        ez = COORD_W'($urandom_range(ROOM_H - 1) * ONE);
      end
      default: ;
    endcase
  endtask

  task automatic random_query();
    logic [COORD_W-1:0] sx, sz, ex, ez;
    pick_segment(sx, sz, ex, ez);
    query(sx, sz, ex, ez);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    query(0, 0, COORD_MAX, COORD_MAX);
    query(COORD_MAX, 0, 0, COORD_MAX);
    send_item(stlos_pkg::OP_WRITE, '0, '0, 1'b0, '0, '0, '0, '0);
    put_wall(0, 1'b1);
    send_item(stlos_pkg::OP_WRITE, '1, '1, 1'b1, '1, '1, '1, '1);
    set_walls.push_back(TILE_COUNT - 1);
    put_wall(7 * ROOM_H + 8, 1'b1);
    // straight through a wall tile
    query(7 * ONE + 128, 0, 7 * ONE + 128, COORD_MAX);
    // point on the infinite line of a wall edge, and one off every line
    query(7 * ONE, 100, 7 * ONE, 100);
    query(100, 100, 100, 100);
    // collinear with an edge without overlap, and parallel off the line
    query(1000, 0, 2000, 0);
    query(1000, 10, 2000, 10);
    // ending exactly on a wall corner, and stopping one step short of an edge
    query(0, 1000, 7 * ONE, 8 * ONE);
    query(7 * ONE - 1, 0, 7 * ONE - 1, 8 * ONE - 1);
    query(0, 0, 0, 0);
    query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    // wholly inside a wall tile, touching no edge
    query(7 * ONE + 10, 8 * ONE + 10, 7 * ONE + 200, 8 * ONE + 200);
    // clear walls again and repeat
    put_wall(7 * ROOM_H + 8, 1'b0);
    query(7 * ONE + 128, 0, 7 * ONE + 128, COORD_MAX);
    put_wall(TILE_COUNT - 1, 1'b0);
    put_wall(0, 1'b0);
    query(0, 0, COORD_MAX, COORD_MAX);
    set_walls.delete();
  endtask

  // Rounds of map building followed by bursts of queries
  task automatic test_random_rooms(input int rounds);
    int n_writes;
    int n_queries;
    for (int r = 0; r < rounds; r++) begin
      // drop the previous map in most rounds
      if ($urandom_range(3) != 0) begin
        while (set_walls.size() > 0) put_wall(set_walls.pop_front(), 1'b0);
      end
      n_writes  = ($urandom_range(4) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
      n_queries = $urandom_range(24, 8);
      for (int w = 0; w < n_writes; w++) begin
        put_wall($urandom_range(TILE_COUNT - 1), $urandom_range(9) != 0);
      end
      for (int q = 0; q < n_queries; q++) begin
        // a stray write now and then, between queries
        if ($urandom_range(9) == 0) begin
          put_wall($urandom_range(TILE_COUNT - 1), 1'($urandom_range(1)));
        end
        random_query();
      end
    end
  endtask

  // Mixed traffic with no idling on either side
  task automatic test_back_to_back(input int count);
    idle_on <= 1'b0;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 35) begin
        put_wall($urandom_range(TILE_COUNT - 1), 1'($urandom_range(1)));
      end else begin
        random_query();
      end
    end
    idle_on <= 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sampling, receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  // Sample handshakes mid-cycle so the rising-edge processes see settled values
  always @(negedge clk_i) begin
    in_take_s  = rst_ni && in_valid_i && !in_stall_o;
    out_take_s = rst_ni && out_valid_o && !out_stall_i;
    blocked_s  = blocked_o;
  end

  // Stall the result channel at random while idling is enabled
  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  // Compare each result transfer with the oldest predicted result
  always @(posedge clk_i) begin : result_check
    bit want;
    if (out_take_s) begin
      queries_seen++;
      if (blocked_s) blocked_seen++;
      if (blocked_pending_q.size() == 0) begin
        if (errors < 10) $display("ERROR: result blocked=%0b with no query pending", blocked_s);
        errors++;
      end else begin
        want = blocked_pending_q.pop_front();
        if (want !== blocked_s) begin
          if (errors < 10) begin
            $display("ERROR: result %0d blocked expected %0b actual %0b",
                     queries_seen, want, blocked_s);
          end
          errors++;
        end
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (in_take_s || out_take_s || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, blocked_pending_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    func_i         <= stlos_pkg::OP_WRITE;
    tile_x_i       <= '0;
    tile_z_i       <= '0;
    tile_is_wall_i <= 1'b0;
    start_x_i      <= '0;
    start_z_i      <= '0;
    end_x_i        <= '0;
    end_z_i        <= '0;
    out_stall_i    <= 1'b0;
    idle_on        <= 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_rooms(45);
    test_back_to_back(200);

    // Drain: wait for every owed result, then watch for strays
    in_valid_i <= 1'b0;
    while (blocked_pending_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    errors += blocked_pending_q.size();

    $display("Run covered %0d transfers in: tile writes and segment queries on varied maps.",
             items_sent);
    $display("%0d query results compared, %0d blocked, %0d mismatches.",
             queries_seen, blocked_seen, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
